FILE: hdl/fvwd_pkg.sv
// Shared types and constants for the four-voice wavetable DDS/PWM unit.
// Used by fvwd_lane and by the top level; depends on nothing else.
`default_nettype none

package fvwd_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned PHASE_W      = 10;
  localparam int unsigned PHASE_MAX    = 1023;
  localparam int unsigned PWM_TOP      = 1023;
  localparam int unsigned DUTY_W       = 16;
  localparam int unsigned VOL_W        = 7;
  localparam int unsigned FREQ_W       = 10;
  localparam int unsigned TABLE_LEN    = 1024;
  localparam int unsigned TABLE_COUNT  = 3;
  localparam int unsigned TBL_DEPTH    = TABLE_COUNT * TABLE_LEN;
  localparam int unsigned TBL_AW       = 12;
  localparam int unsigned CFG_W        = 40;

  localparam logic [DUTY_W-1:0]  DUTY_HALF = DUTY_W'(PWM_TOP >> 1);
  localparam logic [DUTY_W-1:0]  DUTY_TOP  = DUTY_W'(PWM_TOP);
  localparam logic [VOL_W-1:0]   VOL_FULL  = VOL_W'(127);

  typedef enum logic [1:0] {
    MODE_SINE   = 2'd0,
    MODE_TRI    = 2'd1,
    MODE_RAMP   = 2'd2,
    MODE_SQUARE = 2'd3
  } wave_mode_t;

  typedef enum logic [1:0] {
    CFG_ENABLE = 2'd0,
    CFG_MODES  = 2'd1,
    CFG_VOLUME = 2'd2,
    CFG_FREQ   = 2'd3
  } cfg_index_t;

  // per-lane handshake events for one cycle
  typedef struct packed {
    logic tick;     // sample tick accepted this cycle
    logic adv;      // staged tick moves to the output word
    logic gate;
    logic restart;
  } lane_ctl_t;

  typedef struct packed {
    logic              enable;
    wave_mode_t        mode;
    logic [VOL_W-1:0]  vol;
    logic [FREQ_W-1:0] freq;
  } lane_cfg_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [DUTY_W-1:0] data;
  } tbl_wr_t;

endpackage

`default_nettype wire

FILE: hdl/four_voice_wavetable_dds_pwm_unit.sv
// Top level of the four-voice wavetable DDS/PWM unit: stream handshake,
// configuration registers, four fvwd_lane copies and the result word.
// Depends on fvwd_pkg and fvwd_lane.
//
//  channel  | direction | accepted when          | carries
//  ---------+-----------+------------------------+---------------------------------
//  in_*     | slave     | in_tvalid & in_tready  | load word or sample tick
//  out_*    | master    | out_tvalid & out_tready| four duty values per tick
//  cfg_*    | write     | cfg_we                 | enable, modes, volumes, freqs
//
// One word is taken every cycle while the output keeps up. A tick's result word
// is built in order: the phase add and the table read in each lane register when
// the tick is accepted, and the duty select loads the held-duty registers, which
// are the result word, when the staged tick advances to the output. Loads give
// no result and write all four lane tables at once.
// Reset clears phases and returns every duty to half period; table contents
// are left as they are. A stalled output holds the result word, takes one more
// tick into the stage and then drops in_tready until the result word is taken.
`default_nettype none

module four_voice_wavetable_dds_pwm_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: gate_mask[3:0], restart_mask[7:4], table_sel[9:8],
  //           table_addr[19:10], table_word[35:20], zero fill [39:36]
  input  wire logic [39:0] in_tdata,
  // in_tuser: op (0 sample tick, 1 load)
  input  wire logic        in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: duty_ch0[15:0], duty_ch1[31:16], duty_ch2[47:32], duty_ch3[63:48]
  output logic [63:0]      out_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [39:0] cfg_wdata
);
  import fvwd_pkg::*;

  logic [NUM_CHANNELS-1:0]        enable_r;
  logic [2*NUM_CHANNELS-1:0]      modes_r;
  logic [VOL_W*NUM_CHANNELS-1:0]  vols_r;
  logic [FREQ_W*NUM_CHANNELS-1:0] freqs_r;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic in_acc, tick_acc, load_acc, adv;

  logic [3:0]  gate_in, restart_in;
  logic [1:0]  sel_in;
  logic [9:0]  addr_in;
  logic [15:0] word_in;

  tbl_wr_t                 wr;
  lane_ctl_t               ctl  [NUM_CHANNELS];
  lane_cfg_t               lcfg [NUM_CHANNELS];
  logic [DUTY_W-1:0]       duty [NUM_CHANNELS];

  assign gate_in    = in_tdata[3:0];
  assign restart_in = in_tdata[7:4];
  assign sel_in     = in_tdata[9:8];
  assign addr_in    = in_tdata[19:10];
  assign word_in    = in_tdata[35:20];

  // Handshake: the staged tick moves into the result word when that slot
  // is empty or being taken; a new word enters whenever the stage frees up.
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;
  assign tick_acc  = in_acc && !in_tuser;
  assign load_acc  = in_acc && in_tuser;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (tick_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Configuration registers; the index covers exactly the four registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= '0;
      modes_r  <= '0;
      vols_r   <= '1;
      freqs_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_ENABLE: enable_r <= cfg_wdata[NUM_CHANNELS-1:0];
        CFG_MODES:  modes_r  <= cfg_wdata[2*NUM_CHANNELS-1:0];
        CFG_VOLUME: vols_r   <= cfg_wdata[VOL_W*NUM_CHANNELS-1:0];
        CFG_FREQ:   freqs_r  <= cfg_wdata[FREQ_W*NUM_CHANNELS-1:0];
      endcase
    end
  end

  // Broadcast table loads; a load naming the fourth table is dropped.
  always_comb begin
    wr.we   = load_acc && (sel_in < 2'(TABLE_COUNT));
    wr.addr = {sel_in, addr_in};
    wr.data = word_in;
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    always_comb begin
      ctl[c].tick     = tick_acc;
      ctl[c].adv      = adv;
      ctl[c].gate     = gate_in[c];
      ctl[c].restart  = restart_in[c];
      lcfg[c].enable  = enable_r[c];
      lcfg[c].mode    = wave_mode_t'(modes_r[2*c +: 2]);
      lcfg[c].vol     = vols_r[VOL_W*c +: VOL_W];
      lcfg[c].freq    = freqs_r[FREQ_W*c +: FREQ_W];
    end

    fvwd_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[c]),
      .cfg   (lcfg[c]),
      .wr    (wr),
      .duty  (duty[c])
    );

    // The held duties change only when a tick moves into the result slot,
    // so they double as the result word.
    assign out_tdata[DUTY_W*c +: DUTY_W] = duty[c];
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: hdl/fvwd_lane.sv
// One oscillator lane: phase accumulator, private copy of the three
// wavetables, and the held duty value. Depends on fvwd_pkg.
`default_nettype none

module fvwd_lane (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire fvwd_pkg::lane_ctl_t       ctl,
  input  wire fvwd_pkg::lane_cfg_t       cfg,
  input  wire fvwd_pkg::tbl_wr_t         wr,
  output logic [fvwd_pkg::DUTY_W-1:0]    duty
);
  import fvwd_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  logic [PHASE_W:0]   sum;
  logic [PHASE_W:0]   wrapped;
  logic [PHASE_W-1:0] base;
  logic               run;
  logic               rd_en;
  logic [TBL_AW-1:0]  rd_addr;

  // staged tick
  logic               comp_r, gate_r, sq_r, sq_hi_r;
  logic [2:0]         shift_r;
  logic [DUTY_W-1:0]  rd_r;

  logic [DUTY_W-1:0]  tbl_mem [TBL_DEPTH];

  always_comb begin
    base    = ctl.restart ? '0 : phase_r;
    sum     = {1'b0, base} + {1'b0, cfg.freq};
    wrapped = (sum > (PHASE_W+1)'(PHASE_MAX)) ? sum - (PHASE_W+1)'(PHASE_MAX) : sum;
    run     = ctl.tick && cfg.enable && ctl.gate;
    phase_nxt = run ? wrapped[PHASE_W-1:0] : phase_r;
    rd_en   = run && (cfg.mode != MODE_SQUARE);
    rd_addr = {cfg.mode, wrapped[PHASE_W-1:0]};
  end

  always_comb begin
    duty_nxt = duty_r;
    if (ctl.adv && comp_r) begin
      if (!gate_r) begin
        duty_nxt = DUTY_HALF;
      end else if (sq_r) begin
        duty_nxt = sq_hi_r ? DUTY_TOP : '0;
      end else begin
        duty_nxt = rd_r >> shift_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      duty_r  <= DUTY_HALF;
    end else begin
      phase_r <= phase_nxt;
      duty_r  <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick) begin
      comp_r  <= cfg.enable;
      gate_r  <= ctl.gate;
      sq_r    <= (cfg.mode == MODE_SQUARE);
      sq_hi_r <= (wrapped >= (PHASE_W+1)'(PHASE_MAX >> 1));
      shift_r <= 3'((VOL_FULL - cfg.vol) >> 4);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tbl_mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_r <= tbl_mem[rd_addr];
    end
  end

  assign duty = duty_r;

endmodule

`default_nettype wire
